FILE: hw/rtl/iet_pkg.sv
// Package for the input event tracker: operation codes, controller states,
// default sizes and fixed field widths. No dependencies.
`default_nettype none

package iet_pkg;

	localparam int DATA_W = 32;
	localparam int MODE_W = 4;
	localparam int QIDX_W = 8;

	// Defaults for the top-level parameters; key and button counts are powers of two
	localparam int FIFO_DEPTH_DEF     = 32;
	localparam int KEY_COUNT_DEF      = 256;
	localparam int BUTTON_COUNT_DEF   = 4;
	localparam int HIT_COUNT_BITS_DEF = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_KEY_DOWN    = 4'd0,
		MODE_KEY_UP      = 4'd1,
		MODE_KEY_CHAR    = 4'd2,
		MODE_MOUSE_DOWN  = 4'd3,
		MODE_MOUSE_UP    = 4'd4,
		MODE_WHEEL       = 4'd5,
		MODE_KEY_HELD    = 4'd6,
		MODE_KEY_HIT     = 4'd7,
		MODE_CHAR_POP    = 4'd8,
		MODE_KEY_FLUSH   = 4'd9,
		MODE_BTN_HELD    = 4'd10,
		MODE_BTN_HIT     = 4'd11,
		MODE_CLICK_POP   = 4'd12,
		MODE_MOUSE_FLUSH = 4'd13,
		MODE_WHEEL_TOTAL = 4'd14,
		MODE_WHEEL_DELTA = 4'd15
	} mode_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_MEM,
		ST_UPD,
		ST_FLUSH,
		ST_RESP
	} state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iet_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No package dependency.
`default_nettype none

module iet_ram #(
	parameter int WIDTH  = 17,
	parameter int DEPTH  = 256,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/input_event_tracker_core.sv
// Input event tracker top level: controller, key table RAM, shared FIFO RAM
// for the character and click queues, button and wheel registers.
// Depends on iet_pkg and iet_ram.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   in      | into      | in_valid / in_ready | mode, event_data, query_index
//   out     | out of    | out_valid/out_ready | read_value
//
// Each item passes through accept, RAM read, modify and write back, and result
// load; the registered read data of the key table and FIFO RAMs sets this.
// A key flush adds a sweep of the key table, one entry cleared per cycle.
// After reset the key table is cleared the same way: in_ready stays low until
// the sweep is done. A held result waits in the output register while the
// next item is taken; the block stalls only when a new result finds it full.
`default_nettype none

module input_event_tracker_core
	import iet_pkg::*;
#(
	parameter int FIFO_DEPTH     = FIFO_DEPTH_DEF,
	parameter int KEY_COUNT      = KEY_COUNT_DEF,
	parameter int BUTTON_COUNT   = BUTTON_COUNT_DEF,
	parameter int HIT_COUNT_BITS = HIT_COUNT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [MODE_W-1:0]        mode,
	input  wire logic signed [DATA_W-1:0] event_data,
	input  wire logic [QIDX_W-1:0]        query_index,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      read_value
);

	localparam int KW   = $clog2(KEY_COUNT);
	localparam int BW   = $clog2(BUTTON_COUNT);
	localparam int FW   = $clog2(FIFO_DEPTH);
	localparam int PW   = $clog2(2 * FIFO_DEPTH);
	localparam int HB   = HIT_COUNT_BITS;
	localparam int KE_W = HB + 1;
	localparam int FRAM_DEPTH = 2 * (2 ** FW);

	state_t state_q, state_d;

	mode_t              mode_q;
	logic [DATA_W-1:0]  data_q;
	logic [QIDX_W-1:0]  qidx_q;
	logic [DATA_W-1:0]  res_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  read_value_q;
	logic [KW-1:0]      sweep_q;

	logic [PW-1:0]      char_wp_q, char_rp_q, click_wp_q, click_rp_q;
	logic [DATA_W-1:0]  wheel_total_q, wheel_last_q;
	logic               btn_held_q [BUTTON_COUNT];
	logic [HB-1:0]      btn_hit_q  [BUTTON_COUNT];

	logic [KW-1:0]      key_idx;
	logic [BW-1:0]      btn_d, btn_qi;
	logic               key_we;
	logic [KW-1:0]      key_waddr;
	logic [KE_W-1:0]    key_wdata, key_rd;
	logic               key_held;
	logic [HB-1:0]      key_cnt;
	logic               fifo_we;
	logic [FW:0]        fifo_waddr, fifo_raddr;
	logic [DATA_W-1:0]  fifo_rd;
	logic               char_full, click_full, char_empty, click_empty;
	logic               sweep_last, out_free;

	function automatic logic [HB-1:0] bump(input logic [HB-1:0] c);
		return (c == {HB{1'b1}}) ? c : c + 1'b1;
	endfunction

	function automatic logic [FW-1:0] slot(input logic [PW-1:0] p);
		logic [PW-1:0] s;
		s = (p >= PW'(FIFO_DEPTH)) ? p - PW'(FIFO_DEPTH) : p;
		return s[FW-1:0];
	endfunction

	function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
		return (p == PW'(2 * FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic is_full(input logic [PW-1:0] wp, input logic [PW-1:0] rp);
		logic [PW:0] used;
		used = {1'b0, wp} + (PW + 1)'(2 * FIFO_DEPTH) - {1'b0, rp};
		if (used >= (PW + 1)'(2 * FIFO_DEPTH)) begin
			used = used - (PW + 1)'(2 * FIFO_DEPTH);
		end
		return used == (PW + 1)'(FIFO_DEPTH);
	endfunction

	assign key_idx  = (mode_q == MODE_KEY_HELD || mode_q == MODE_KEY_HIT)
		? KW'(qidx_q) : data_q[KW-1:0];
	assign btn_d    = data_q[BW-1:0];
	assign btn_qi   = BW'(qidx_q);
	assign key_held = key_rd[HB];
	assign key_cnt  = key_rd[HB-1:0];

	assign char_full   = is_full(char_wp_q, char_rp_q);
	assign click_full  = is_full(click_wp_q, click_rp_q);
	assign char_empty  = (char_wp_q == char_rp_q);
	assign click_empty = (click_wp_q == click_rp_q);
	assign sweep_last  = (sweep_q == KW'(KEY_COUNT - 1));
	assign out_free    = !out_valid_q || out_ready;

	iet_ram #(
		.WIDTH (KE_W),
		.DEPTH (KEY_COUNT),
		.ADDR_W(KW)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.raddr(key_idx),
		.rdata(key_rd)
	);

	// Lower half holds the character queue, upper half the click queue
	iet_ram #(
		.WIDTH (DATA_W),
		.DEPTH (FRAM_DEPTH),
		.ADDR_W(FW + 1)
	) u_fifo_ram (
		.clk  (clk),
		.we   (fifo_we),
		.waddr(fifo_waddr),
		.wdata(data_q),
		.raddr(fifo_raddr),
		.rdata(fifo_rd)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_MEM;
			end
			ST_MEM: begin
				state_d = ST_UPD;
			end
			ST_UPD: begin
				state_d = (mode_q == MODE_KEY_FLUSH) ? ST_FLUSH : ST_RESP;
			end
			ST_FLUSH: begin
				if (sweep_last) state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs: handshake and RAM controls
	always_comb begin
		in_ready   = 1'b0;
		key_we     = 1'b0;
		key_waddr  = key_idx;
		key_wdata  = key_rd;
		fifo_we    = 1'b0;
		fifo_waddr = {1'b0, slot(char_wp_q)};
		fifo_raddr = (mode_q == MODE_CLICK_POP) ? {1'b1, slot(click_rp_q)}
			: {1'b0, slot(char_rp_q)};
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_INIT, ST_FLUSH: begin
				key_we    = 1'b1;
				key_waddr = sweep_q;
				key_wdata = '0;
			end
			ST_UPD: begin
				unique case (mode_q)
					MODE_KEY_DOWN: begin
						key_we    = 1'b1;
						key_wdata = {1'b1, bump(key_cnt)};
					end
					MODE_KEY_UP: begin
						key_we    = 1'b1;
						key_wdata = {1'b0, key_cnt};
					end
					MODE_KEY_HIT: begin
						key_we    = 1'b1;
						key_wdata = {key_held, {HB{1'b0}}};
					end
					MODE_KEY_CHAR: begin
						fifo_we = !char_full;
					end
					MODE_MOUSE_DOWN: begin
						fifo_we    = !click_full;
						fifo_waddr = {1'b1, slot(click_wp_q)};
					end
					default: begin
					end
				endcase
			end
			ST_MEM, ST_RESP: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_FLUSH) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			if (state_q == ST_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item capture and result register
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			mode_q <= mode_t'(mode);
			data_q <= unsigned'(event_data);
			qidx_q <= query_index;
		end
		if (state_q == ST_RESP && out_free) begin
			read_value_q <= res_q;
		end
		if (state_q == ST_UPD) begin
			unique case (mode_q)
				MODE_KEY_HELD:    res_q <= DATA_W'(key_held);
				MODE_KEY_HIT:     res_q <= DATA_W'(key_cnt);
				MODE_CHAR_POP:    res_q <= char_empty ? '0 : fifo_rd;
				MODE_CLICK_POP:   res_q <= click_empty ? '0 : fifo_rd;
				MODE_BTN_HELD:    res_q <= DATA_W'(btn_held_q[btn_qi]);
				MODE_BTN_HIT:     res_q <= DATA_W'(btn_hit_q[btn_qi]);
				MODE_WHEEL_TOTAL: res_q <= wheel_total_q;
				MODE_WHEEL_DELTA: res_q <= wheel_total_q - wheel_last_q;
				MODE_KEY_DOWN, MODE_KEY_UP, MODE_KEY_CHAR, MODE_MOUSE_DOWN,
				MODE_MOUSE_UP, MODE_WHEEL, MODE_KEY_FLUSH, MODE_MOUSE_FLUSH: begin
					res_q <= '0;
				end
			endcase
		end
	end

	// Queue pointers, buttons and wheel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_wp_q     <= '0;
			char_rp_q     <= '0;
			click_wp_q    <= '0;
			click_rp_q    <= '0;
			wheel_total_q <= '0;
			wheel_last_q  <= '0;
			for (int i = 0; i < BUTTON_COUNT; i++) begin
				btn_held_q[i] <= 1'b0;
				btn_hit_q[i]  <= '0;
			end
		end else if (state_q == ST_UPD) begin
			unique case (mode_q)
				MODE_KEY_CHAR: begin
					if (!char_full) char_wp_q <= ptr_next(char_wp_q);
				end
				MODE_MOUSE_DOWN: begin
					btn_held_q[btn_d] <= 1'b1;
					btn_hit_q[btn_d]  <= bump(btn_hit_q[btn_d]);
					if (!click_full) click_wp_q <= ptr_next(click_wp_q);
				end
				MODE_MOUSE_UP: begin
					btn_held_q[btn_d] <= 1'b0;
				end
				MODE_WHEEL: begin
					wheel_total_q <= wheel_total_q + data_q;
				end
				MODE_CHAR_POP: begin
					if (!char_empty) char_rp_q <= ptr_next(char_rp_q);
				end
				MODE_CLICK_POP: begin
					if (!click_empty) click_rp_q <= ptr_next(click_rp_q);
				end
				MODE_KEY_FLUSH: begin
					char_wp_q <= '0;
					char_rp_q <= '0;
				end
				MODE_BTN_HIT: begin
					btn_hit_q[btn_qi] <= '0;
				end
				MODE_MOUSE_FLUSH: begin
					click_wp_q <= '0;
					click_rp_q <= '0;
					for (int i = 0; i < BUTTON_COUNT; i++) begin
						btn_held_q[i] <= 1'b0;
						btn_hit_q[i]  <= '0;
					end
				end
				MODE_WHEEL_DELTA: begin
					wheel_last_q <= wheel_total_q;
				end
				default: begin
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

endmodule

`default_nettype wire

FILE: hw/rtl/iet_checker.sv
// Port-level checker for input_event_tracker_core, attached by bind.
// Depends on iet_pkg.
`default_nettype none

module iet_checker
	import iet_pkg::*;
(
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_valid,
	input wire logic                     in_ready,
	input wire logic [MODE_W-1:0]        mode,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [DATA_W-1:0] read_value
);

	// One item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while previous item in progress");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_value))
		else $error("result dropped or changed while stalled");

	// Held queries answer 0 or 1, checked when the output is empty at the accept
	a_held_bit: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid
		&& (mode == MODE_KEY_HELD || mode == MODE_BTN_HELD)
		|-> ##4 (out_valid && read_value[DATA_W-1:1] == '0))
		else $error("held query result is not a single bit");

	// Events return zero
	a_event_zero: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid && mode <= MODE_WHEEL
		|-> ##4 (out_valid && read_value == '0))
		else $error("event item returned a nonzero result");

endmodule

bind input_event_tracker_core iet_checker u_iet_checker (.*);

`default_nettype wire

FILE: sim/input_event_tracker_core_tb.sv
// Self-checking testbench for input_event_tracker_core: a shadow of the key,
// button, FIFO and wheel state predicts every read_value and checks it in order.
// Depends on iet_pkg and the input_event_tracker_core RTL.
module input_event_tracker_core_tb;
	import iet_pkg::*;

	localparam int PTR_W       = $clog2(2 * FIFO_DEPTH_DEF);
	localparam int CHAR_QUEUE  = 0;
	localparam int CLICK_QUEUE = 1;
	localparam int HIT_LIMIT   = (1 << HIT_COUNT_BITS_DEF) - 1;
	localparam int PHASE_ITEMS = 560;
	localparam int PRESS_COUNT = 24;
	localparam int REPORT_CAP  = 100;
	localparam int unsigned CYCLE_LIMIT = 3000000;

	typedef enum {
		SEQ_NOISE,
		SEQ_CHARS,
		SEQ_CLICKS,
		SEQ_KEY_PRESS,
		SEQ_BUTTON,
		SEQ_WHEEL,
		SEQ_FLUSH
	} seq_kind_t;

	class tracker_shadow;
		bit                          key_held [KEY_COUNT_DEF];
		bit [HIT_COUNT_BITS_DEF-1:0] key_counts [KEY_COUNT_DEF];
		bit                          btn_held [BUTTON_COUNT_DEF];
		bit [HIT_COUNT_BITS_DEF-1:0] btn_hits [BUTTON_COUNT_DEF];
		bit [DATA_W-1:0]             queue_mem [2][FIFO_DEPTH_DEF];
		bit [PTR_W-1:0]              wr_ptr [2];
		bit [PTR_W-1:0]              rd_ptr [2];
		bit [DATA_W-1:0]             wheel_total;
		bit [DATA_W-1:0]             wheel_seen;
		logic [DATA_W-1:0]           pending_reads [$];
		int                          mismatches;

		function new();
			foreach (key_held[i]) begin
				key_held[i]   = 1'b0;
				key_counts[i] = '0;
			end
			foreach (btn_held[i]) begin
				btn_held[i] = 1'b0;
				btn_hits[i] = '0;
			end
			foreach (wr_ptr[i]) begin
				wr_ptr[i] = '0;
				rd_ptr[i] = '0;
			end
			wheel_total = '0;
			wheel_seen  = '0;
			mismatches  = 0;
		endfunction

		// Drop the value when the queue is full.
		function void push_entry(int sel, bit [DATA_W-1:0] value);
			bit [PTR_W-1:0] used;
			used = wr_ptr[sel] - rd_ptr[sel];
			if (used == FIFO_DEPTH_DEF)
				return;
			queue_mem[sel][wr_ptr[sel][PTR_W-2:0]] = value;
			wr_ptr[sel]++;
		endfunction

		function bit [DATA_W-1:0] pop_entry(int sel);
			bit [DATA_W-1:0] value;
			if (wr_ptr[sel] == rd_ptr[sel])
				return '0;
			value = queue_mem[sel][rd_ptr[sel][PTR_W-2:0]];
			rd_ptr[sel]++;
			return value;
		endfunction

		function void absorb_event(mode_t m, bit [DATA_W-1:0] d, bit [QIDX_W-1:0] q);
			int              dk;
			int              db;
			int              qk;
			int              qb;
			bit [DATA_W-1:0] r;
			dk = d % KEY_COUNT_DEF;
			db = d % BUTTON_COUNT_DEF;
			qk = q % KEY_COUNT_DEF;
			qb = q % BUTTON_COUNT_DEF;
			r  = '0;
			case (m)
				MODE_KEY_DOWN: begin
					if (key_counts[dk] != HIT_LIMIT)
						key_counts[dk]++;
					key_held[dk] = 1'b1;
				end
				MODE_KEY_UP:     key_held[dk] = 1'b0;
				MODE_KEY_CHAR:   push_entry(CHAR_QUEUE, d);
				MODE_MOUSE_DOWN: begin
					if (btn_hits[db] != HIT_LIMIT)
						btn_hits[db]++;
					btn_held[db] = 1'b1;
					push_entry(CLICK_QUEUE, d);
				end
				MODE_MOUSE_UP:   btn_held[db] = 1'b0;
				MODE_WHEEL:      wheel_total += d;
				MODE_KEY_HELD:   r = key_held[qk];
				MODE_KEY_HIT: begin
					r = key_counts[qk];
					key_counts[qk] = '0;
				end
				MODE_CHAR_POP:   r = pop_entry(CHAR_QUEUE);
				MODE_KEY_FLUSH: begin
					wr_ptr[CHAR_QUEUE] = '0;
					rd_ptr[CHAR_QUEUE] = '0;
					foreach (key_held[i]) begin
						key_held[i]   = 1'b0;
						key_counts[i] = '0;
					end
				end
				MODE_BTN_HELD:   r = btn_held[qb];
				MODE_BTN_HIT: begin
					r = btn_hits[qb];
					btn_hits[qb] = '0;
				end
				MODE_CLICK_POP:  r = pop_entry(CLICK_QUEUE);
				MODE_MOUSE_FLUSH: begin
					wr_ptr[CLICK_QUEUE] = '0;
					rd_ptr[CLICK_QUEUE] = '0;
					foreach (btn_held[i]) begin
						btn_held[i] = 1'b0;
						btn_hits[i] = '0;
					end
				end
				MODE_WHEEL_TOTAL: r = wheel_total;
				MODE_WHEEL_DELTA: begin
					r = wheel_total - wheel_seen;
					wheel_seen = wheel_total;
				end
			endcase
			pending_reads.push_back(r);
		endfunction

		function void compare_read_value(logic [DATA_W-1:0] got);
			logic [DATA_W-1:0] want;
			if (pending_reads.size() == 0) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: read_value with nothing pending, expected none actual %h",
						$time, got);
				mismatches++;
				return;
			end
			want = pending_reads.pop_front();
			if (got !== want) begin
				if (mismatches < REPORT_CAP)
					$display("%0t: read_value expected %h actual %h", $time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	mode_t                    mode        = MODE_KEY_DOWN;
	logic signed [DATA_W-1:0] event_data  = '0;
	logic [QIDX_W-1:0]        query_index = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic signed [DATA_W-1:0] read_value;

	tracker_shadow tracker = new();
	int            tx_idle_pct = 36;
	int            rx_idle_pct = 49;
	int            items_sent  = 0;
	int unsigned   cycle_count = 0;

	input_event_tracker_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.mode        (mode),
		.event_data  (event_data),
		.query_index (query_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.read_value  (read_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (out_valid && out_ready)
			tracker.compare_read_value(read_value);
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Favor a few low codes so downs, ups and queries meet on the same key.
	function automatic bit [DATA_W-1:0] key_code();
		return $urandom_range(1) ? DATA_W'($urandom_range(7)) : DATA_W'($urandom);
	endfunction

	function automatic bit [QIDX_W-1:0] index_pick();
		return $urandom_range(1) ? QIDX_W'($urandom_range(7)) : QIDX_W'($urandom_range(255));
	endfunction

	task automatic send_item(mode_t m, bit [DATA_W-1:0] d, bit [QIDX_W-1:0] q);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		mode        <= m;
		event_data  <= d;
		query_index <= q;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		tracker.absorb_event(m, d, q);
		items_sent++;
	endtask

	// Hold off the sender until every predicted read has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending_reads.size() != 0);
	endtask

	task automatic run_random(int count);
		int              stop_at;
		int              pick;
		int              burst;
		int              pops;
		bit [DATA_W-1:0] d;
		seq_kind_t       kind;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 30)      kind = SEQ_NOISE;
			else if (pick < 45) kind = SEQ_CHARS;
			else if (pick < 55) kind = SEQ_CLICKS;
			else if (pick < 75) kind = SEQ_KEY_PRESS;
			else if (pick < 85) kind = SEQ_BUTTON;
			else if (pick < 96) kind = SEQ_WHEEL;
			else                kind = SEQ_FLUSH;
			case (kind)
				SEQ_NOISE:
					send_item(mode_t'($urandom_range(15)), key_code(), index_pick());
				SEQ_CHARS: begin
					// Bursts past the depth exercise the drop on a full queue.
					burst = $urandom_range(1, 40);
					repeat (burst)
						send_item(MODE_KEY_CHAR, $urandom, index_pick());
					pops = $urandom_range(1, burst + 2);
					repeat (pops)
						send_item(MODE_CHAR_POP, $urandom, index_pick());
				end
				SEQ_CLICKS: begin
					burst = $urandom_range(1, 40);
					repeat (burst) begin
						d = $urandom;
						send_item(MODE_MOUSE_DOWN, d, index_pick());
						if ($urandom_range(3) == 0)
							send_item(MODE_MOUSE_UP, d, index_pick());
					end
					send_item(MODE_BTN_HELD, $urandom, index_pick());
					send_item(MODE_BTN_HIT, $urandom, index_pick());
					pops = $urandom_range(1, burst + 2);
					repeat (pops)
						send_item(MODE_CLICK_POP, $urandom, index_pick());
				end
				SEQ_KEY_PRESS: begin
					d = key_code();
					repeat ($urandom_range(1, 3))
						send_item(MODE_KEY_DOWN, d, index_pick());
					send_item(MODE_KEY_HELD, $urandom, d[QIDX_W-1:0]);
					if ($urandom_range(3) != 0)
						send_item(MODE_KEY_UP, d, index_pick());
					send_item(MODE_KEY_HELD, $urandom, d[QIDX_W-1:0]);
					send_item(MODE_KEY_HIT, $urandom, d[QIDX_W-1:0]);
				end
				SEQ_BUTTON: begin
					d = $urandom;
					send_item(MODE_MOUSE_DOWN, d, index_pick());
					send_item(MODE_BTN_HELD, $urandom, d[QIDX_W-1:0]);
					send_item(MODE_MOUSE_UP, d, index_pick());
					send_item(MODE_BTN_HELD, $urandom, d[QIDX_W-1:0]);
					send_item(MODE_BTN_HIT, $urandom, d[QIDX_W-1:0]);
					send_item(MODE_CLICK_POP, $urandom, index_pick());
				end
				SEQ_WHEEL: begin
					repeat ($urandom_range(1, 4))
						send_item(MODE_WHEEL, $urandom, index_pick());
					send_item(mode_t'($urandom_range(1) ? MODE_WHEEL_TOTAL : MODE_WHEEL_DELTA),
						$urandom, index_pick());
					send_item(MODE_WHEEL_DELTA, $urandom, index_pick());
				end
				SEQ_FLUSH:
					send_item(mode_t'($urandom_range(1) ? MODE_KEY_FLUSH : MODE_MOUSE_FLUSH),
						$urandom, index_pick());
			endcase
		end
	endtask

	initial begin
		bit [DATA_W-1:0] sat_key;
		bit [DATA_W-1:0] sat_btn;
		bit [DATA_W-1:0] d;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: field extremes and every operation.
		send_item(MODE_KEY_DOWN, 32'hFFFF_FFFF, 8'h00);
		send_item(MODE_KEY_DOWN, 32'h0000_0000, 8'hFF);
		send_item(MODE_KEY_HELD, 32'h0000_0000, 8'hFF);
		send_item(MODE_KEY_UP, 32'h7FFF_FF00, 8'h00);
		send_item(MODE_KEY_HELD, 32'hFFFF_FFFF, 8'h00);
		send_item(MODE_KEY_HIT, 32'h0000_0000, 8'hFF);
		send_item(MODE_KEY_HIT, 32'h0000_0000, 8'hFF);
		send_item(MODE_CHAR_POP, 32'h0000_0000, 8'h00);
		send_item(MODE_KEY_CHAR, 32'h8000_0000, 8'h00);
		send_item(MODE_KEY_CHAR, 32'h7FFF_FFFF, 8'hFF);
		send_item(MODE_CHAR_POP, 32'h0000_0000, 8'h00);
		send_item(MODE_MOUSE_DOWN, 32'hFFFF_FFFF, 8'h00);
		send_item(MODE_MOUSE_DOWN, 32'h0000_0000, 8'h00);
		send_item(MODE_BTN_HELD, 32'h0000_0000, 8'hFF);
		send_item(MODE_MOUSE_UP, 32'h0000_0003, 8'h00);
		send_item(MODE_BTN_HELD, 32'h0000_0000, 8'h03);
		send_item(MODE_BTN_HIT, 32'h0000_0000, 8'h00);
		send_item(MODE_CLICK_POP, 32'h0000_0000, 8'h00);
		send_item(MODE_KEY_FLUSH, 32'h0000_0000, 8'h00);
		send_item(MODE_CHAR_POP, 32'h0000_0000, 8'h00);
		send_item(MODE_MOUSE_FLUSH, 32'h0000_0000, 8'h00);
		send_item(MODE_CLICK_POP, 32'h0000_0000, 8'h00);
		send_item(MODE_WHEEL, 32'h7FFF_FFFF, 8'h00);
		send_item(MODE_WHEEL, 32'h8000_0000, 8'h00);
		send_item(MODE_WHEEL_TOTAL, 32'h0000_0000, 8'h00);
		send_item(MODE_WHEEL_DELTA, 32'h0000_0000, 8'h00);
		send_item(MODE_WHEEL_DELTA, 32'h0000_0000, 8'h00);
		drain_results();

		// Press one key and one button many times back to back, then read the counts.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		sat_key = $urandom;
		sat_btn = $urandom;
		repeat (PRESS_COUNT) begin
			d = $urandom;
			d[7:0] = sat_key[7:0];
			send_item(MODE_KEY_DOWN, d, index_pick());
			d = $urandom;
			d[1:0] = sat_btn[1:0];
			send_item(MODE_MOUSE_DOWN, d, index_pick());
		end
		send_item(MODE_KEY_HIT, $urandom, sat_key[QIDX_W-1:0]);
		send_item(MODE_BTN_HIT, $urandom, sat_btn[QIDX_W-1:0]);
		send_item(MODE_KEY_HIT, $urandom, sat_key[QIDX_W-1:0]);
		drain_results();

		tx_idle_pct = 36;
		rx_idle_pct = 49;
		run_random(PHASE_ITEMS);
		drain_results();

		tx_idle_pct = 49;
		rx_idle_pct = 36;
		run_random(PHASE_ITEMS);
		drain_results();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_random(PHASE_ITEMS);
		drain_results();

		// Catch any stray result after the last expected one.
		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_reads.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
